### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the tag cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/lrc_pkg.sv
// Shared types and constants of the LRU tag cache.
package lrc_pkg;

	// Parameter defaults
	localparam int MAX_SLOTS_DEF = 8;
	localparam int KEY_BITS_DEF  = 32;
	localparam int DATA_BITS_DEF = 32;

	// Fixed field widths
	localparam int REQ_W = 2;
	localparam int CAP_W = 7;
	localparam int OCC_W = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd8;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_GET   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PROBE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

	// Operation broadcast to every cell
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_TOUCH,
		OP_FILL,
		OP_CLEAR,
		OP_DROP
	} cell_op_t;

	// Control seen by one cell: the broadcast operation and its own select
	typedef struct packed {
		cell_op_t op;
		logic     sel;
	} cell_ctl_t;

endpackage

### hw/rtl/lrc_cell.sv
// One cache slot: valid bit, key, data and recency rank.
module lrc_cell #(
	parameter int KEY_BITS  = lrc_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = lrc_pkg::DATA_BITS_DEF,
	parameter int RANK_W    = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrc_pkg::cell_ctl_t   ctl,
	input  logic [RANK_W-1:0]    ref_rank,
	input  logic [KEY_BITS-1:0]  wr_key,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic [KEY_BITS-1:0]  cmp_key,
	output logic                 valid,
	output logic [RANK_W-1:0]    rank,
	output logic [DATA_BITS-1:0] data,
	output logic                 match
);

	logic                 valid_q;
	logic [RANK_W-1:0]    rank_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [DATA_BITS-1:0] data_q;

	// Compare the incoming key against the stored one
	assign match = valid_q && (key_q == cmp_key);
	assign valid = valid_q;
	assign rank  = rank_q;
	assign data  = data_q;

	// Update valid bit and rank from the broadcast operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			unique case (ctl.op)
				lrc_pkg::OP_IDLE: begin
				end
				lrc_pkg::OP_TOUCH: begin
					if (ctl.sel) begin
						rank_q <= '0;
					end else if (valid_q && (rank_q < ref_rank)) begin
						rank_q <= rank_q + RANK_W'(1);
					end
				end
				lrc_pkg::OP_FILL: begin
					if (ctl.sel) begin
						valid_q <= 1'b1;
						rank_q  <= '0;
					end else if (valid_q) begin
						rank_q <= rank_q + RANK_W'(1);
					end
				end
				lrc_pkg::OP_CLEAR: begin
					valid_q <= 1'b0;
					rank_q  <= '0;
				end
				lrc_pkg::OP_DROP: begin
					if (ctl.sel) begin
						valid_q <= 1'b0;
						rank_q  <= '0;
					end else if (valid_q && (rank_q > ref_rank)) begin
						rank_q <= rank_q - RANK_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Load key and data on a fill of this slot
	always_ff @(posedge clk) begin
		if ((ctl.op == lrc_pkg::OP_FILL) && ctl.sel) begin
			key_q  <= wr_key;
			data_q <= wr_data;
		end
	end

endmodule

### hw/rtl/lru_tag_cache.sv
// Top level of the fully associative LRU tag cache.
//
// Usage:
//   Request channel: drive req_type, key and payload with start high; the item
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with hit, evicted, data_out and
//   occupancy. The receiver cannot stall it; take the result in that cycle.
//   Config channel: cfg_data is the capacity, written when cfg_valid and
//   cfg_ready are both high. cfg_ready is low while a request is in flight.
// Timing:
//   A request is handled in order: the key compare of all slots is registered at
//   acceptance, the slot update happens in the next cycle, and done follows.
//   The next request is accepted in the cycle done is high, so the block never
//   works on two requests at once.
//   A capacity write starts a sweep over all MAX_SLOTS slots that empties slots
//   beyond the new capacity one per cycle; busy is high meanwhile.
// Reset:
//   All slots are empty, occupancy is zero and capacity is 8.
`include "assert_macros.svh"

module lru_tag_cache #(
	parameter int MAX_SLOTS = lrc_pkg::MAX_SLOTS_DEF,
	parameter int KEY_BITS  = lrc_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = lrc_pkg::DATA_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [lrc_pkg::REQ_W-1:0]  req_type,
	input  logic [KEY_BITS-1:0]        key,
	input  logic [DATA_BITS-1:0]       payload,
	output logic                       done,
	output logic                       hit,
	output logic                       evicted,
	output logic [DATA_BITS-1:0]       data_out,
	output logic [lrc_pkg::OCC_W-1:0]  occupancy,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lrc_pkg::CAP_W-1:0]  cfg_data
);

	localparam int RANK_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int IDX_W  = RANK_W;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ACT   = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	logic [1:0]                state_q;
	logic [lrc_pkg::CAP_W-1:0] cap_q;
	logic [CNT_W-1:0]          occ_q;
	logic [IDX_W-1:0]          sweep_q;
	logic                      done_q;
	logic                      hit_q;
	logic                      evicted_q;
	logic [DATA_BITS-1:0]      data_q;

	logic [lrc_pkg::REQ_W-1:0] req_s1;
	logic [KEY_BITS-1:0]       key_s1;
	logic [DATA_BITS-1:0]      payload_s1;
	logic [MAX_SLOTS-1:0]      match_s1;

	logic [MAX_SLOTS-1:0]      cell_valid;
	logic [MAX_SLOTS-1:0]      cell_match;
	logic [RANK_W-1:0]         cell_rank [MAX_SLOTS];
	logic [DATA_BITS-1:0]      cell_data [MAX_SLOTS];
	lrc_pkg::cell_ctl_t        cell_ctl  [MAX_SLOTS];

	logic [CNT_W-1:0]          eff;
	logic [MAX_SLOTS-1:0]      en;
	logic [MAX_SLOTS-1:0]      free;
	logic [MAX_SLOTS-1:0]      lowest_free;
	logic [MAX_SLOTS-1:0]      victim;
	logic [MAX_SLOTS-1:0]      sweep_hot;
	logic [MAX_SLOTS-1:0]      pick;
	logic [MAX_SLOTS-1:0]      cmd_sel;
	logic [RANK_W-1:0]         pick_rank;
	logic [DATA_BITS-1:0]      pick_data;
	lrc_pkg::cell_op_t         cmd_op;
	logic                      any_hit;
	logic                      do_evict;
	logic                      sweep_drop;
	logic [CNT_W-1:0]          occ_next;
	logic                      accept;
	logic                      cfg_write;

	// Saturate capacity to the number of slots built
	assign eff = (cap_q > lrc_pkg::CAP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
		: cap_q[CNT_W-1:0];

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign accept    = start && !busy;
	assign cfg_write = cfg_valid && cfg_ready;

	// Per-slot enable, free and victim flags, sweep decode
	for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_flags
		assign en[g]        = (CNT_W'(g) < eff);
		assign sweep_hot[g] = (sweep_q == IDX_W'(g));
		assign victim[g]    = cell_valid[g] && en[g]
			&& (cell_rank[g] == RANK_W'(occ_q - CNT_W'(1)));
	end

	assign free        = en & ~cell_valid;
	assign lowest_free = free & (~free + MAX_SLOTS'(1));
	assign any_hit     = |match_s1;
	assign pick        = (state_q == ST_SWEEP) ? sweep_hot : match_s1;

	// Select rank and data of the picked slot
	always_comb begin
		pick_rank = '0;
		pick_data = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (pick[i]) begin
				pick_rank = pick_rank | cell_rank[i];
				pick_data = pick_data | cell_data[i];
			end
		end
	end

	assign sweep_drop = |(sweep_hot & cell_valid & ~en);

	// Decide the operation broadcast to the cells
	always_comb begin
		cmd_op   = lrc_pkg::OP_IDLE;
		cmd_sel  = '0;
		do_evict = 1'b0;
		occ_next = occ_q;
		if (state_q == ST_ACT) begin
			unique case (req_s1)
				lrc_pkg::REQ_GET: begin
					if (any_hit) begin
						cmd_op  = lrc_pkg::OP_TOUCH;
						cmd_sel = match_s1;
					end
				end
				lrc_pkg::REQ_PROBE: begin
				end
				lrc_pkg::REQ_PUT: begin
					if (any_hit) begin
						cmd_op  = lrc_pkg::OP_TOUCH;
						cmd_sel = match_s1;
					end else if (eff != '0) begin
						cmd_op = lrc_pkg::OP_FILL;
						if (free != '0) begin
							cmd_sel  = lowest_free;
							occ_next = occ_q + CNT_W'(1);
						end else begin
							cmd_sel  = victim;
							do_evict = 1'b1;
						end
					end
				end
				lrc_pkg::REQ_CLEAR: begin
					cmd_op   = lrc_pkg::OP_CLEAR;
					occ_next = '0;
				end
				default: begin
				end
			endcase
		end else if ((state_q == ST_SWEEP) && sweep_drop) begin
			cmd_op   = lrc_pkg::OP_DROP;
			cmd_sel  = sweep_hot;
			occ_next = occ_q - CNT_W'(1);
		end
	end

	// Row of slot cells
	for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
		assign cell_ctl[g] = '{op: cmd_op, sel: cmd_sel[g]};

		lrc_cell #(
			.KEY_BITS  (KEY_BITS),
			.DATA_BITS (DATA_BITS),
			.RANK_W    (RANK_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl[g]),
			.ref_rank (pick_rank),
			.wr_key   (key_s1),
			.wr_data  (payload_s1),
			.cmp_key  (key),
			.valid    (cell_valid[g]),
			.rank     (cell_rank[g]),
			.data     (cell_data[g]),
			.match    (cell_match[g])
		);
	end

	// Capture the request and the compare result at acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= req_type;
			key_s1     <= key;
			payload_s1 <= payload;
			match_s1   <= cell_match & en;
		end
	end

	// Sequence requests and capacity sweeps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= lrc_pkg::CAP_RESET;
			sweep_q <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_ACT);
			occ_q  <= occ_next;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ACT;
					end else if (cfg_write) begin
						cap_q   <= cfg_data;
						sweep_q <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_ACT: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (sweep_q == IDX_W'(MAX_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result for its strobe cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_ACT) begin
			hit_q     <= any_hit && (req_s1 != lrc_pkg::REQ_CLEAR);
			evicted_q <= do_evict;
			data_q    <= (any_hit && (req_s1 == lrc_pkg::REQ_GET)) ? pick_data : '0;
		end
	end

	assign done      = done_q;
	assign hit       = hit_q;
	assign evicted   = evicted_q;
	assign data_out  = data_q;
	assign occupancy = lrc_pkg::OCC_W'(occ_q);

	`ASSERT_CLK(a_act_done, (state_q == ST_ACT) |=> done_q, "request without result")
	`ASSERT_CLK(a_occ_count, $countones(cell_valid) == occ_q, "occupancy count mismatch")
	`ASSERT_CLK(a_occ_cap, (state_q == ST_IDLE) |-> (occ_q <= eff), "occupancy above capacity")
	`ASSERT_CLK(a_one_match, (state_q == ST_ACT) |-> $onehot0(match_s1), "duplicate key in cache")
	`ASSERT_CLK(a_evict_miss, (done_q && evicted_q) |-> !hit_q, "eviction on a hit")

endmodule
